>>> sv/cseq_pkg.sv
package cseq_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int VALUE_W    = 32;
    localparam int KIND_W     = 3;
    localparam int COUNT_W    = 7;
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [KIND_W-1:0]     kind_t;

    localparam kind_t KIND_RESTART = 3'd0;
    localparam kind_t KIND_ADVANCE = 3'd1;
    localparam kind_t KIND_INSERT  = 3'd2;
    localparam kind_t KIND_ATTACH  = 3'd3;
    localparam kind_t KIND_REMOVE  = 3'd4;

    // per-cell shift control
    typedef struct packed {
        logic shift_up;
        logic shift_down;
    } cell_ctrl_t;

    // whole-chain stack operation
    typedef struct packed {
        logic push;
        logic pop;
        logic replace;
    } stack_ctrl_t;

endpackage

>>> sv/cseq_cell.sv
module cseq_cell (
    input  logic               clk,
    input  cseq_pkg::cell_ctrl_t ctrl,
    input  cseq_pkg::data_t    up_value,
    input  cseq_pkg::data_t    down_value,
    output cseq_pkg::data_t    value
);
    import cseq_pkg::*;

    data_t value_reg;
    data_t value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.shift_up)
        begin
            value_next = up_value;
        end
        else if (ctrl.shift_down)
        begin
            value_next = down_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

>>> sv/cseq_stack.sv
module cseq_stack (
    input  logic                  clk,
    input  cseq_pkg::stack_ctrl_t ctrl,
    input  cseq_pkg::data_t       push_value,
    output cseq_pkg::data_t       top_value,
    output cseq_pkg::data_t       second_value
);
    import cseq_pkg::*;

    data_t      values   [CAPACITY];
    data_t      up_vals  [CAPACITY];
    data_t      down_vals[CAPACITY];
    cell_ctrl_t cell_ctrl[CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        // cell zero is the top of the stack: it takes the new value on push or replace
        if (i == 0)
        begin : g_top
            assign up_vals[i]            = push_value;
            assign cell_ctrl[i].shift_up = ctrl.push | ctrl.replace;
        end
        else
        begin : g_body
            assign up_vals[i]            = values[i-1];
            assign cell_ctrl[i].shift_up = ctrl.push;
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign down_vals[i] = '0;
        end
        else
        begin : g_inner
            assign down_vals[i] = values[i+1];
        end

        assign cell_ctrl[i].shift_down = ctrl.pop;

        cseq_cell u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl[i]),
            .up_value   (up_vals[i]),
            .down_value (down_vals[i]),
            .value      (values[i])
        );
    end

    assign top_value    = values[0];
    assign second_value = values[1];

endmodule

>>> sv/cursor_sequence_store.sv
// result is registered, one request in flight; most commands have it the cycle after they are taken,
// while restart and an insert with no current entry first move the entries ahead of the cursor
// one a cycle from the left to the right chain (drain state), then load it in a final state;
// with no entries ahead of the cursor they load it like the rest
// the right chain holds the current entry and those after it, the left chain those before it
// reset (async, active low) empties the store and clears control; cell contents are not cleared
module cursor_sequence_store (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  cseq_pkg::kind_t        kind,
    input  logic [31:0]            entry_value,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [31:0]            current_value,
    output logic                   has_current,
    output logic [6:0]             item_count,
    output logic                   error
);
    import cseq_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_DRAIN = 3'b010,
        ST_FINAL = 3'b100
    } state_t;

    state_t state_reg, state_next;
    cnt_t   left_cnt_reg, left_cnt_next;
    cnt_t   right_cnt_reg, right_cnt_next;
    kind_t  op_kind_reg, op_kind_next;
    data_t  op_value_reg, op_value_next;

    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] current_value_reg, current_value_next;
    logic               has_current_reg, has_current_next;
    logic [COUNT_W-1:0] item_count_reg, item_count_next;
    logic               error_reg, error_next;

    stack_ctrl_t lctrl, rctrl;
    data_t       lpush_value, rpush_value;
    data_t       ltop, lsecond, rtop, rsecond;
    data_t       in_data;
    data_t       res_value;
    logic        res_has;
    logic        res_error;
    logic        load_out;
    logic        accept;
    logic        full;
    logic        right_empty;

    assign in_data     = DATA_WIDTH'(entry_value);
    assign full        = (CNT_W'(left_cnt_reg + right_cnt_reg) >= CNT_W'(CAPACITY));
    assign right_empty = (right_cnt_reg == '0);
    assign in_ready    = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept      = in_valid && in_ready;

    cseq_stack u_left (
        .clk          (clk),
        .ctrl         (lctrl),
        .push_value   (lpush_value),
        .top_value    (ltop),
        .second_value (lsecond)
    );

    cseq_stack u_right (
        .clk          (clk),
        .ctrl         (rctrl),
        .push_value   (rpush_value),
        .top_value    (rtop),
        .second_value (rsecond)
    );

    always_comb
    begin
        state_next     = state_reg;
        left_cnt_next  = left_cnt_reg;
        right_cnt_next = right_cnt_reg;
        op_kind_next   = op_kind_reg;
        op_value_next  = op_value_reg;
        lctrl          = '0;
        rctrl          = '0;
        lpush_value    = rtop;
        rpush_value    = in_data;
        load_out       = 1'b0;
        // unchanged view of the current entry unless a command says otherwise
        res_value      = right_empty ? '0 : rtop;
        res_has        = !right_empty;
        res_error      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_kind_next  = kind;
                    op_value_next = in_data;
                    load_out      = 1'b1;
                    case (kind)
                        KIND_RESTART:
                        begin
                            if (left_cnt_reg != '0)
                            begin
                                load_out   = 1'b0;
                                state_next = ST_DRAIN;
                            end
                        end
                        KIND_ADVANCE, KIND_REMOVE:
                        begin
                            if (right_empty)
                            begin
                                res_error = 1'b1;
                            end
                            else
                            begin
                                rctrl.pop      = 1'b1;
                                right_cnt_next = right_cnt_reg - CNT_W'(1);
                                if (kind == KIND_ADVANCE)
                                begin
                                    lctrl.push    = 1'b1;
                                    left_cnt_next = left_cnt_reg + CNT_W'(1);
                                end
                                res_has   = (right_cnt_reg > CNT_W'(1));
                                res_value = res_has ? rsecond : '0;
                            end
                        end
                        KIND_INSERT:
                        begin
                            if (full)
                            begin
                                res_error = 1'b1;
                            end
                            else if (!right_empty || left_cnt_reg == '0)
                            begin
                                rctrl.push     = 1'b1;
                                right_cnt_next = right_cnt_reg + CNT_W'(1);
                                res_value      = in_data;
                                res_has        = 1'b1;
                            end
                            else
                            begin
                                // no cursor: bring everything back to the front first
                                load_out   = 1'b0;
                                state_next = ST_DRAIN;
                            end
                        end
                        KIND_ATTACH:
                        begin
                            if (full)
                            begin
                                res_error = 1'b1;
                            end
                            else
                            begin
                                if (!right_empty)
                                begin
                                    // old current moves behind, new value takes the top
                                    rctrl.replace = 1'b1;
                                    lctrl.push    = 1'b1;
                                    left_cnt_next = left_cnt_reg + CNT_W'(1);
                                end
                                else
                                begin
                                    rctrl.push     = 1'b1;
                                    right_cnt_next = right_cnt_reg + CNT_W'(1);
                                end
                                res_value = in_data;
                                res_has   = 1'b1;
                            end
                        end
                        default:
                        begin
                            res_error = 1'b1;
                        end
                    endcase
                end
            end
            ST_DRAIN:
            begin
                lctrl.pop      = 1'b1;
                rctrl.push     = 1'b1;
                rpush_value    = ltop;
                left_cnt_next  = left_cnt_reg - CNT_W'(1);
                right_cnt_next = right_cnt_reg + CNT_W'(1);
                if (left_cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                load_out   = 1'b1;
                state_next = ST_IDLE;
                if (op_kind_reg == KIND_INSERT)
                begin
                    rctrl.push     = 1'b1;
                    rpush_value    = op_value_reg;
                    right_cnt_next = right_cnt_reg + CNT_W'(1);
                    res_value      = op_value_reg;
                    res_has        = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next     = out_valid_reg && !out_ready;
        current_value_next = current_value_reg;
        has_current_next   = has_current_reg;
        item_count_next    = item_count_reg;
        error_next         = error_reg;
        if (load_out)
        begin
            out_valid_next     = 1'b1;
            current_value_next = VALUE_W'(res_value);
            has_current_next   = res_has;
            item_count_next    = COUNT_W'(CNT_W'(left_cnt_next + right_cnt_next));
            error_next         = res_error;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            left_cnt_reg  <= '0;
            right_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            left_cnt_reg  <= left_cnt_next;
            right_cnt_reg <= right_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_kind_reg       <= op_kind_next;
        op_value_reg      <= op_value_next;
        current_value_reg <= current_value_next;
        has_current_reg   <= has_current_next;
        item_count_reg    <= item_count_next;
        error_reg         <= error_next;
    end

    assign out_valid     = out_valid_reg;
    assign current_value = current_value_reg;
    assign has_current   = has_current_reg;
    assign item_count    = item_count_reg;
    assign error         = error_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((CNT_W+1)'(left_cnt_reg) + (CNT_W+1)'(right_cnt_reg)) <= (CNT_W+1)'(CAPACITY))
        else $error("stored entries exceed capacity");

    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> (left_cnt_reg != '0))
        else $error("drain with empty left chain");

    a_drain_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN && left_cnt_reg > CNT_W'(1)) |=> (ltop == $past(lsecond)))
        else $error("left chain did not shift during drain");

    a_final_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINAL) |=> (state_reg == ST_IDLE && out_valid_reg))
        else $error("final step did not deliver a result");

    a_error_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && res_error) |=>
            (left_cnt_reg == $past(left_cnt_reg) && right_cnt_reg == $past(right_cnt_reg)))
        else $error("refused request changed the store");

    a_no_current_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !has_current_reg) |-> (current_value_reg == '0))
        else $error("value reported without a current entry");

endmodule

>>> dv/cursor_sequence_store_tb.sv
`timescale 1ns / 1ps

module cursor_sequence_store_tb;

    import cseq_pkg::*;

    localparam int    TIMEOUT_NS   = 5_000_000;
    localparam int    DRAIN_CYCLES = 200;
    localparam int    HOLD_CYCLES  = 300;
    localparam kind_t KIND_UNUSED_LO = 3'd5;
    localparam kind_t KIND_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [31:0]        current_value;
        logic               has_current;
        logic [COUNT_W-1:0] item_count;
        logic               error;
    } seq_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    kind_t       kind;
    logic [31:0] entry_value;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] current_value;
    logic        has_current;
    logic [6:0]  item_count;
    logic        error;

    // shadow of the store, updated as each request is taken
    data_t store_values [CAPACITY];
    int    store_count;
    int    cursor_at;
    bit    cursor_on;

    seq_result_t expected_results [$];
    int          mismatch_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_request;

    cursor_sequence_store DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .entry_value   (entry_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .current_value (current_value),
        .has_current   (has_current),
        .item_count    (item_count),
        .error         (error)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic seq_result_t apply_command(input kind_t k, input logic [31:0] v);
        seq_result_t r;
        int          i;
        int          slot;
        bit          refused;
        refused = 1'b0;
        case (k)
            KIND_RESTART:
            begin
                cursor_at = 0;
                cursor_on = (store_count > 0);
            end
            KIND_ADVANCE:
            begin
                if (!cursor_on)
                    refused = 1'b1;
                else if (cursor_at + 1 >= store_count)
                begin
                    cursor_at = 0;
                    cursor_on = 1'b0;
                end
                else
                    cursor_at++;
            end
            KIND_INSERT, KIND_ATTACH:
            begin
                if (store_count >= CAPACITY)
                    refused = 1'b1;
                else
                begin
                    if (k == KIND_INSERT)
                        slot = cursor_on ? cursor_at : 0;
                    else
                        slot = cursor_on ? cursor_at + 1 : store_count;
                    for (i = store_count; i > slot; i--)
                        store_values[i] = store_values[i-1];
                    store_values[slot] = v;
                    store_count++;
                    cursor_at = slot;
                    cursor_on = 1'b1;
                end
            end
            KIND_REMOVE:
            begin
                if (!cursor_on || cursor_at >= store_count)
                    refused = 1'b1;
                else
                begin
                    for (i = cursor_at; i + 1 < store_count; i++)
                        store_values[i] = store_values[i+1];
                    store_count--;
                    if (cursor_at >= store_count)
                    begin
                        cursor_at = 0;
                        cursor_on = 1'b0;
                    end
                end
            end
            default:
                refused = 1'b1;
        endcase
        if (cursor_on && cursor_at < store_count)
        begin
            r.current_value = store_values[cursor_at];
            r.has_current   = 1'b1;
        end
        else
        begin
            r.current_value = '0;
            r.has_current   = 1'b0;
        end
        r.item_count = COUNT_W'(store_count);
        r.error      = refused;
        return r;
    endfunction

    // handshakes are sampled mid-cycle, where every signal is settled
    always @(negedge clk)
    begin : result_check
        seq_result_t want;
        if (rst_n === 1'b1)
        begin
            if (in_valid && in_ready)
                expected_results.push_back(apply_command(kind, entry_value));
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual %h %b %0d %b",
                             $time, current_value, has_current, item_count, error);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (current_value !== want.current_value)
                    begin
                        $display("%0t: current_value expected %h actual %h",
                                 $time, want.current_value, current_value);
                        mismatch_count++;
                    end
                    if (has_current !== want.has_current)
                    begin
                        $display("%0t: has_current expected %b actual %b",
                                 $time, want.has_current, has_current);
                        mismatch_count++;
                    end
                    if (item_count !== want.item_count)
                    begin
                        $display("%0t: item_count expected %0d actual %0d",
                                 $time, want.item_count, item_count);
                        mismatch_count++;
                    end
                    if (error !== want.error)
                    begin
                        $display("%0t: error expected %b actual %b",
                                 $time, want.error, error);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // receiver: random stalls, plus long hold-offs on demand
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

    // called at a rising edge; returns at the edge where the request is taken
    task automatic send_request(input kind_t k, input logic [31:0] v);
        bit taken;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        entry_value <= v;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    function automatic logic [31:0] random_value();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_directed_cases();
        send_request(KIND_RESTART, $urandom());      // empty store
        send_request(KIND_ADVANCE, $urandom());      // no current entry
        send_request(KIND_REMOVE, $urandom());
        send_request(KIND_UNUSED_LO, 32'hFFFF_FFFF);
        send_request(KIND_UNUSED_HI, 32'h0000_0000);
        send_request(KIND_INSERT, 32'h0000_0000);    // no cursor, goes to the front
        send_request(KIND_ATTACH, 32'hFFFF_FFFF);
        send_request(KIND_ADVANCE, $urandom());      // steps off the end
        send_request(KIND_ADVANCE, $urandom());
        send_request(KIND_INSERT, 32'hA5A5_A5A5);
        while (cursor_on)
            send_request(KIND_ADVANCE, $urandom());
        send_request(KIND_ATTACH, 32'h5A5A_5A5A);    // no cursor, goes to the end
        send_request(KIND_INSERT, 32'hC3C3_3C3C);
        send_request(KIND_RESTART, $urandom());
        send_request(KIND_REMOVE, $urandom());       // cursor moves to the follower
        while (cursor_at + 1 < store_count)
            send_request(KIND_ADVANCE, $urandom());
        send_request(KIND_REMOVE, $urandom());       // last entry, cursor leaves
        send_request(KIND_REMOVE, $urandom());
    endtask

    task automatic test_random_traffic(input int n_items, input int grow_pct);
        int    pick;
        kind_t k;
        repeat (n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
                k = kind_t'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
            else if (pick < 12)
                k = KIND_RESTART;
            else if (pick < 36)
                k = (cursor_on || $urandom_range(3) == 0) ? KIND_ADVANCE : KIND_RESTART;
            else if ($urandom_range(99) < grow_pct)
                k = $urandom_range(1) ? KIND_INSERT : KIND_ATTACH;
            else
                k = KIND_REMOVE;
            send_request(k, random_value());
        end
    endtask

    task automatic test_full_store();
        while (store_count < CAPACITY)
            send_request($urandom_range(1) ? KIND_INSERT : KIND_ATTACH, random_value());
        send_request(KIND_INSERT, random_value());
        send_request(KIND_ATTACH, random_value());
        send_request(KIND_RESTART, $urandom());
        repeat (5)
            send_request(KIND_ADVANCE, $urandom());
        send_request(KIND_INSERT, random_value());
        send_request(KIND_RESTART, $urandom());
        while (store_count > 0)
            send_request(KIND_REMOVE, $urandom());
    endtask

    task automatic test_receiver_hold_off();
        hold_request = HOLD_CYCLES;
        test_random_traffic(40, 60);
    endtask

    initial
    begin
        store_count    = 0;
        cursor_at      = 0;
        cursor_on      = 1'b0;
        mismatch_count = 0;
        hold_request   = 0;
        send_idle_pct  = 37;
        recv_idle_pct  = 55;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        kind        <= KIND_RESTART;
        entry_value <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_traffic(300, 55);

        send_idle_pct = 55;
        recv_idle_pct = 37;
        test_full_store();
        test_random_traffic(200, 50);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_receiver_hold_off();
        test_random_traffic(200, 60);

        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> cursor_sequence_store.f
sv/cseq_pkg.sv
sv/cseq_cell.sv
sv/cseq_stack.sv
sv/cursor_sequence_store.sv
dv/cursor_sequence_store_tb.sv
